### sv/cps_pkg.sv
// Shared types, codes and constants for the counter priority task scheduler.
package cps_pkg;

	localparam int NUM_TASKS_DEF = 64;
	localparam int MAX_REFILLS   = 20;
	localparam int REF_W         = $clog2(MAX_REFILLS + 1);
	localparam int REQ_W         = 3;
	localparam int SLOT_W        = 6;
	localparam int PRIO_W        = 8;
	localparam int CNT_W         = 16;
	localparam int DEP_W         = 8;
	localparam int EXT_W         = 9;
	localparam logic [PRIO_W-1:0] INIT_PRIO_RST = 8'd1;
	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK   = 3'd0,
		REQ_YIELD  = 3'd1,
		REQ_EXIT   = 3'd2,
		REQ_CREATE = 3'd3,
		REQ_PDIS   = 3'd4,
		REQ_PEN    = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_REFILL,
		ST_REFILL_END,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [PRIO_W-1:0]       prio;
		logic signed [CNT_W-1:0] cnt;
		logic [DEP_W-1:0]        dep;
	} row_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic scan_start;
		logic refill_start;
		logic walk;
		logic commit;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_last;
		logic sched;
		logic pass_again;
		logic out_free;
	} dp_stat_t;

endpackage

### sv/cps_ctrl.sv
// Sequencer for event handling, scan and refill passes.
module cps_ctrl import cps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t st,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (st.sched) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.walk = 1'b1;
				if (st.walk_last) state_d = ST_SCAN_END;
			end
			ST_SCAN_END: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (st.pass_again) begin
					cmd.refill_start = 1'b1;
					state_d          = ST_REFILL;
				end else begin
					cmd.commit = 1'b1;
					state_d    = ST_DONE;
				end
			end
			ST_REFILL: begin
				cmd.walk = 1'b1;
				if (st.walk_last) state_d = ST_REFILL_END;
			end
			ST_REFILL_END: begin
				cmd.scan_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/cps_dpath.sv
// Slot table, scan/refill pipeline and result register.
module cps_dpath import cps_pkg::*; #(
	parameter int NUM_TASKS = NUM_TASKS_DEF,
	localparam int IDX_W = $clog2(NUM_TASKS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          st,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [SLOT_W-1:0] slot,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic              cfg_we,
	input  logic [PRIO_W-1:0] cfg_data,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [SLOT_W-1:0] active_task,
	output logic [SLOT_W-1:0] previous_task,
	output logic              switched
);

	// slot table: priority, counter, depth per row; rows never written read as zero
	row_t mem [NUM_TASKS];
	logic [NUM_TASKS-1:0] rvld_q, occ_q, run_q;
	logic [PRIO_W-1:0]    prio0_q;

	logic [REQ_W-1:0]  req_q;
	logic [IDX_W-1:0]  new_slot_q;
	logic              new_ok_q;
	logic [PRIO_W-1:0] new_prio_q;
	logic [IDX_W-1:0]  running_q, prev_q, idx_q, pick_q;
	logic signed [CNT_W-1:0] best_q;
	logic [REF_W-1:0]  refills_q;
	logic              mode_q;

	row_t             rd_s1;
	logic             rvld_s1, occ_s1, run_s1, v_s1;
	logic [IDX_W-1:0] idx_s1;

	logic              out_valid_q, sw_q;
	logic [SLOT_W-1:0] cur_out_q, prev_out_q;

	logic [EXT_W-1:0] slot_ext, cur_ext, prev_ext;
	logic [IDX_W-1:0] rd_addr, waddr, ex_addr;
	logic             rd_en, we, ex_we, sched;
	row_t             row_e, wdata, ex_data;
	logic signed [CNT_W:0]   dec_w, ref_w;
	logic signed [CNT_W-1:0] cnt_tick, cnt_ref;

	assign slot_ext = EXT_W'(slot);
	assign cur_ext  = EXT_W'(running_q);
	assign prev_ext = EXT_W'(prev_q);

	assign rd_en   = cmd.take | cmd.walk;
	assign rd_addr = cmd.take ? running_q : idx_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1   <= mem[rd_addr];
			rvld_s1 <= rvld_q[rd_addr];
			occ_s1  <= occ_q[rd_addr];
			run_s1  <= run_q[rd_addr];
			idx_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// slot 0 priority lives in its own register so config writes land at once
	always_comb begin
		row_e = rvld_s1 ? rd_s1 : '0;
		if (idx_s1 == '0) row_e.prio = prio0_q;
	end

	always_comb begin
		dec_w    = {row_e.cnt[CNT_W-1], row_e.cnt} - (CNT_W+1)'(1);
		cnt_tick = (row_e.cnt == CNT_MIN) ? row_e.cnt : dec_w[CNT_W-1:0];
		ref_w    = {{2{row_e.cnt[CNT_W-1]}}, row_e.cnt[CNT_W-1:1]}
			+ $signed({{(CNT_W+1-PRIO_W){1'b0}}, row_e.prio});
		// floor half plus priority cannot fall below the range, nor rise above it
		cnt_ref  = (!ref_w[CNT_W] && ref_w[CNT_W-1]) ? CNT_MAX : ref_w[CNT_W-1:0];
	end

	always_comb begin
		ex_we   = 1'b0;
		ex_addr = running_q;
		ex_data = row_e;
		sched   = 1'b0;
		case (req_t'(req_q))
			REQ_TICK: begin
				ex_we = 1'b1;
				if (cnt_tick <= 0 && row_e.dep == '0) begin
					ex_data.cnt = '0;
					sched       = 1'b1;
				end else begin
					ex_data.cnt = cnt_tick;
				end
			end
			REQ_YIELD, REQ_EXIT: begin
				ex_we       = 1'b1;
				ex_data.cnt = '0;
				sched       = 1'b1;
			end
			REQ_CREATE: begin
				ex_we        = new_ok_q;
				ex_addr      = new_slot_q;
				ex_data.prio = new_prio_q;
				ex_data.cnt  = $signed({{(CNT_W-PRIO_W){1'b0}}, new_prio_q});
				ex_data.dep  = '0;
			end
			REQ_PDIS: begin
				ex_we = 1'b1;
				if (row_e.dep != '1) ex_data.dep = row_e.dep + DEP_W'(1);
			end
			REQ_PEN: begin
				ex_we = 1'b1;
				if (row_e.dep != '0) ex_data.dep = row_e.dep - DEP_W'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = ex_addr;
		wdata = ex_data;
		if (cmd.exec) begin
			we = ex_we;
		end else if (v_s1 && mode_q && occ_s1) begin
			we        = 1'b1;
			waddr     = idx_s1;
			wdata     = row_e;
			wdata.cnt = cnt_ref;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q      <= req_type;
			new_slot_q <= slot_ext[IDX_W-1:0];
			new_ok_q   <= (slot_ext < EXT_W'(NUM_TASKS));
			new_prio_q <= priority_req;
			prev_q     <= running_q;
		end
		if (cmd.scan_start) begin
			best_q <= -16'sd1;
			pick_q <= '0;
		end else if (v_s1 && !mode_q && occ_s1 && run_s1 && row_e.cnt > best_q) begin
			best_q <= row_e.cnt;
			pick_q <= idx_s1;
		end
		if (cmd.out_load) begin
			cur_out_q  <= cur_ext[SLOT_W-1:0];
			prev_out_q <= prev_ext[SLOT_W-1:0];
			sw_q       <= (running_q != prev_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q      <= '0;
			occ_q       <= NUM_TASKS'(1);
			run_q       <= NUM_TASKS'(1);
			prio0_q     <= INIT_PRIO_RST;
			running_q   <= '0;
			idx_q       <= '0;
			refills_q   <= '0;
			mode_q      <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.walk;
			if (we) rvld_q[waddr] <= 1'b1;
			if (cfg_we) prio0_q <= cfg_data;
			if (cmd.exec) begin
				refills_q <= '0;
				if (req_t'(req_q) == REQ_EXIT) run_q[running_q] <= 1'b0;
				if (req_t'(req_q) == REQ_CREATE && new_ok_q) begin
					occ_q[new_slot_q] <= 1'b1;
					run_q[new_slot_q] <= 1'b1;
					if (new_slot_q == '0) prio0_q <= new_prio_q;
				end
			end
			if (cmd.scan_start) begin
				idx_q  <= '0;
				mode_q <= 1'b0;
			end else if (cmd.refill_start) begin
				idx_q     <= '0;
				mode_q    <= 1'b1;
				refills_q <= refills_q + REF_W'(1);
			end else if (cmd.walk) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.commit) running_q <= pick_q;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.walk_last  = (idx_q == IDX_W'(NUM_TASKS - 1));
	assign st.sched      = sched;
	assign st.pass_again = (best_q == '0) && (refills_q < REF_W'(MAX_REFILLS));
	assign st.out_free   = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign active_task   = cur_out_q;
	assign previous_task = prev_out_q;
	assign switched      = sw_q;

	a_refill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		refills_q <= REF_W'(MAX_REFILLS))
		else $error("refill count beyond limit");

	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(running_q))
		else $error("running slot moved without commit");

	a_pick_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && best_q >= 0 |-> occ_q[pick_q] && run_q[pick_q])
		else $error("picked slot is not a runnable task");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !v_s1 && !cmd.walk)
		else $error("event write collides with table walk");

endmodule

### sv/counter_priority_task_scheduler.sv
// Top level of the counter priority task scheduler.
//
// Usage:
//   Event channel (in_valid/in_stall, req_type, slot, priority_req): one
//   event per transfer; tick, yield, exit, create, preempt disable/enable.
//   Result channel (out_valid/out_stall): one transfer per event with the
//   current task, the previous task and a switched flag.
//   Config channel (cfg_valid/cfg_ready, init_priority): sets the priority
//   of slot 0; cfg_ready is always high, write only while idle.
// Flow:
//   One event at a time. Events without a pass go through take, execute
//   and done, where the result register is loaded. A pass walks the slot
//   table through its single read port, one slot per cycle; a scan ends
//   in a decide step, and each refill walk is followed by a rescan.
// Reset: slot 0 holds the initial task, running, with the reset priority;
//   no clearing pass is needed, rows never written read as zero.
// Stall: a result waits in the output register; the next event is taken,
//   but its own result is held back until the register has drained.
module counter_priority_task_scheduler import cps_pkg::*; #(
	parameter int NUM_TASKS = NUM_TASKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [SLOT_W-1:0] slot,
	input  logic [PRIO_W-1:0] priority_req,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] active_task,
	output logic [SLOT_W-1:0] previous_task,
	output logic              switched,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [PRIO_W-1:0] init_priority
);

	dp_cmd_t  cmd;
	dp_stat_t st;

	// the user must issue config writes only while idle; the block does not enforce this, and they are always taken
	assign cfg_ready = 1'b1;

	cps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	cps_dpath #(
		.NUM_TASKS (NUM_TASKS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.req_type      (req_type),
		.slot          (slot),
		.priority_req  (priority_req),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (init_priority),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.active_task   (active_task),
		.previous_task (previous_task),
		.switched      (switched)
	);

endmodule
